// ----- hw/rtl/sad_pkg.sv -----
// ----------------------------------------------------------------------------
// sad_pkg
// Shared types, register indexes and reset values of the sensor alarm
// debouncer.
// ----------------------------------------------------------------------------
package sad_pkg;

  localparam int SAMPLE_BITS_DEF = 12;

  localparam int THR_W  = 12;
  localparam int RUN_W  = 8;
  localparam int WARM_W = 16;
  localparam int CFG_DW = 16;
  localparam int CFG_AW = 3;
  localparam int OUT_W  = 8;

  typedef enum logic [1:0] {
    LVL_NORMAL  = 2'd0,
    LVL_ALARM   = 2'd1,
    LVL_UNAVAIL = 2'd2
  } level_e;

  typedef enum logic [CFG_AW-1:0] {
    REG_ALARM_THR   = 3'd0,
    REG_RECOVER_THR = 3'd1,
    REG_RUNS_ALARM  = 3'd2,
    REG_RUNS_NORMAL = 3'd3,
    REG_RUNS_UNAV   = 3'd4,
    REG_WARMUP      = 3'd5
  } reg_idx_e;

  localparam logic [THR_W-1:0]  ALARM_THR_RST   = 12'd1800;
  localparam logic [THR_W-1:0]  RECOVER_THR_RST = 12'd1400;
  localparam logic [RUN_W-1:0]  RUNS_ALARM_RST  = 8'd3;
  localparam logic [RUN_W-1:0]  RUNS_NORMAL_RST = 8'd20;
  localparam logic [RUN_W-1:0]  RUNS_UNAV_RST   = 8'd10;
  localparam logic [WARM_W-1:0] WARMUP_RST      = 16'd1200;
  localparam logic [RUN_W-1:0]  RUN_MAX         = 8'd255;

  typedef struct packed {
    logic [THR_W-1:0]  alarm_thr;
    logic [THR_W-1:0]  recover_thr;
    logic [RUN_W-1:0]  runs_alarm;
    logic [RUN_W-1:0]  runs_normal;
    logic [RUN_W-1:0]  runs_unav;
    logic [WARM_W-1:0] warmup_ticks;
  } cfg_t;

  typedef struct packed {
    logic   taken;
    logic   changed;
    level_e level;
  } result_t;

endpackage

// ----- hw/rtl/sad_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// sad_cfg_regs
// Configuration register bank, plain write port, no read-back.
// ----------------------------------------------------------------------------
module sad_cfg_regs import sad_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ALARM_THR:   cfg_d.alarm_thr    = cfg_wdata_i[THR_W-1:0];
        REG_RECOVER_THR: cfg_d.recover_thr  = cfg_wdata_i[THR_W-1:0];
        REG_RUNS_ALARM:  cfg_d.runs_alarm   = cfg_wdata_i[RUN_W-1:0];
        REG_RUNS_NORMAL: cfg_d.runs_normal  = cfg_wdata_i[RUN_W-1:0];
        REG_RUNS_UNAV:   cfg_d.runs_unav    = cfg_wdata_i[RUN_W-1:0];
        REG_WARMUP:      cfg_d.warmup_ticks = cfg_wdata_i[WARM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alarm_thr    <= ALARM_THR_RST;
      cfg_q.recover_thr  <= RECOVER_THR_RST;
      cfg_q.runs_alarm   <= RUNS_ALARM_RST;
      cfg_q.runs_normal  <= RUNS_NORMAL_RST;
      cfg_q.runs_unav    <= RUNS_UNAV_RST;
      cfg_q.warmup_ticks <= WARMUP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/sad_in_stage.sv -----
// ----------------------------------------------------------------------------
// sad_in_stage
// Input register: captures one sample item, advances with the pipeline.
// ----------------------------------------------------------------------------
module sad_in_stage import sad_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   ok_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   adv_i,
  output logic                   valid_o,
  output logic                   ok_o,
  output logic [SAMPLE_BITS-1:0] sample_o
);

  logic                   valid_q, valid_d;
  logic                   ok_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   load;

  assign in_ready_o = !valid_q || adv_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ok_q     <= ok_i;
      sample_q <= sample_i;
    end
  end

  assign valid_o  = valid_q;
  assign ok_o     = ok_q;
  assign sample_o = sample_q;

endmodule

// ----- hw/rtl/sad_core.sv -----
// ----------------------------------------------------------------------------
// sad_core
// Warmup counter, hysteresis classifier and run-length debounce state.
// ----------------------------------------------------------------------------
module sad_core import sad_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   step_i,
  input  logic                   ok_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output result_t                res_o
);

  localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  level_e            stable_q, stable_d;
  level_e            cand_q, cand_d;
  logic [RUN_W-1:0]  run_q, run_d;
  logic [WARM_W-1:0] warm_cnt_q, warm_cnt_d;
  logic              warmed_q, warmed_d;

  logic [CMP_W-1:0]  smp;
  level_e            raw;
  logic [RUN_W-1:0]  need;
  logic              in_warmup;

  assign smp       = CMP_W'(sample_i);
  assign in_warmup = !warmed_q && (warm_cnt_q < cfg_i.warmup_ticks);

  always_comb begin
    if (!ok_i) begin
      raw = LVL_UNAVAIL;
    end else if (smp > CMP_W'(cfg_i.alarm_thr)) begin
      raw = LVL_ALARM;
    end else if (stable_q == LVL_ALARM && smp > CMP_W'(cfg_i.recover_thr)) begin
      raw = LVL_ALARM;
    end else begin
      raw = LVL_NORMAL;
    end
  end

  always_comb begin
    stable_d   = stable_q;
    cand_d     = cand_q;
    run_d      = run_q;
    warm_cnt_d = warm_cnt_q;
    warmed_d   = warmed_q;
    need       = '0;
    res_o      = '{taken: 1'b0, changed: 1'b0, level: stable_q};
    if (in_warmup) begin
      warm_cnt_d = warm_cnt_q + 1'b1;
    end else begin
      warmed_d    = 1'b1;
      res_o.taken = 1'b1;
      if (raw == cand_q) begin
        run_d = (run_q == RUN_MAX) ? run_q : run_q + 1'b1;
      end else begin
        cand_d = raw;
        run_d  = RUN_W'(1);
      end
      case (cand_d)
        LVL_ALARM:  need = cfg_i.runs_alarm;
        LVL_NORMAL: need = cfg_i.runs_normal;
        default:    need = cfg_i.runs_unav;
      endcase
      if (need == '0) begin
        need = RUN_W'(1);
      end
      if (cand_d != stable_q && run_d >= need) begin
        stable_d      = cand_d;
        run_d         = '0;
        res_o.changed = 1'b1;
      end
      res_o.level = stable_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q   <= LVL_UNAVAIL;
      cand_q     <= LVL_UNAVAIL;
      run_q      <= '0;
      warm_cnt_q <= '0;
      warmed_q   <= 1'b0;
    end else if (step_i) begin
      stable_q   <= stable_d;
      cand_q     <= cand_d;
      run_q      <= run_d;
      warm_cnt_q <= warm_cnt_d;
      warmed_q   <= warmed_d;
    end
  end

endmodule

// ----- hw/rtl/sad_out_reg.sv -----
// ----------------------------------------------------------------------------
// sad_out_reg
// Result register on the master side; holds an item until it is taken.
// ----------------------------------------------------------------------------
module sad_out_reg import sad_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  result_t res_i,
  output logic    adv_o,
  output logic    m_valid_o,
  input  logic    m_ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign adv_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (adv_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && valid_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign res_o     = res_q;

endmodule

// ----- hw/rtl/sensor_alarm_debouncer.sv -----
// ----------------------------------------------------------------------------
// sensor_alarm_debouncer
// Debounced threshold detector with hysteresis for a gas sensor stream.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one sample item per transfer: sample_ok in bit 0,
//   adc_sample above it. Master stream gives exactly one result item per
//   sample: level_state, state_changed, sample_taken.
//   Configuration registers are written through cfg_we_i/cfg_idx_i/
//   cfg_wdata_i while the stream is idle; writes to unused indexes are
//   dropped.
//   Path: input transfer into the input register, then classify/debounce
//   between the input register and the result register.
//   Throughput: 1 item per cycle while m_tready is high; the debounce state steps with each item.
//   Reset: thresholds and run lengths take their defaults, the stable level
//   is unavailable and the warmup count restarts from zero.
//   Stall: while m_tready is low the result register holds its item and
//   the input register fills; s_tready drops only when both are full.
// ----------------------------------------------------------------------------
module sensor_alarm_debouncer import sad_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int IN_W        = ((1 + SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // sample_ok, adc_sample, zero pad
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // level_state, state_changed, sample_taken, pad
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i
);

  cfg_t                   cfg;
  logic                   adv;
  logic                   st_valid;
  logic                   st_ok;
  logic [SAMPLE_BITS-1:0] st_sample;
  result_t                core_res;
  result_t                out_res;

  sad_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  sad_in_stage #(.SAMPLE_BITS(SAMPLE_BITS)) u_in (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .ok_i       (s_tdata[0]),
    .sample_i   (s_tdata[SAMPLE_BITS:1]),
    .adv_i      (adv),
    .valid_o    (st_valid),
    .ok_o       (st_ok),
    .sample_o   (st_sample)
  );

  sad_core #(.SAMPLE_BITS(SAMPLE_BITS)) u_core (
    .clk_i,
    .rst_ni,
    .cfg_i    (cfg),
    .step_i   (st_valid && adv),
    .ok_i     (st_ok),
    .sample_i (st_sample),
    .res_o    (core_res)
  );

  sad_out_reg u_out (
    .clk_i,
    .rst_ni,
    .valid_i   (st_valid),
    .res_i     (core_res),
    .adv_o     (adv),
    .m_valid_o (m_tvalid),
    .m_ready_i (m_tready),
    .res_o     (out_res)
  );

  assign m_tdata = {{(OUT_W-4){1'b0}}, out_res.taken, out_res.changed, out_res.level};

endmodule

// ----- hw/rtl/sad_checker.sv -----
// ----------------------------------------------------------------------------
// sad_checker
// Port-level checks of the sensor alarm debouncer, bound to the top level.
// ----------------------------------------------------------------------------
module sad_checker import sad_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // back-pressure only when the result side is stalled
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("s_tready low without output stall");

  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> (m_tdata[1:0] != 2'd3))
    else $error("illegal level code");

  a_changed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && m_tdata[2]) |-> m_tdata[3])
    else $error("change flagged on an untaken sample");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result item changed");

endmodule

bind sensor_alarm_debouncer sad_checker u_sad_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/sensor_alarm_debouncer_tb.sv -----
// ----------------------------------------------------------------------------
// sensor_alarm_debouncer_tb
// Self-checking bench for the sensor alarm debouncer. A behavioral tracker
// follows warmup, hysteresis classification and run-length debounce for
// every accepted sample and queues the expected level item; each result
// item is checked field by field against the oldest entry. Directed tests
// cover warmup, zero warmup, hysteresis edges, threshold extremes, zero
// run lengths and ignored register writes. A random part then runs streams
// of same-class samples with glitches under many register settings, with
// bursty input and a patterned output stall.
// ----------------------------------------------------------------------------
module sensor_alarm_debouncer_tb;
  import sad_pkg::*;

  localparam int SMP_W    = SAMPLE_BITS_DEF;
  localparam int IN_W     = ((1 + SMP_W + 7) / 8) * 8;
  localparam int WD_LIMIT = 4000;
  localparam logic [CFG_AW-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_AW-1:0] REG_SPARE_7 = 3'd7;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              s_tvalid    = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata     = '0;   // sample_ok, adc_sample, zero pad
  logic              m_tvalid;
  logic              m_tready    = 1'b0;
  logic [OUT_W-1:0]  m_tdata;            // level_state, state_changed, sample_taken, pad
  logic              cfg_we_i    = 1'b0;
  logic [CFG_AW-1:0] cfg_idx_i   = '0;
  logic [CFG_DW-1:0] cfg_wdata_i = '0;

  sensor_alarm_debouncer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // tracker state
  cfg_t              shadow_cfg = '{ALARM_THR_RST, RECOVER_THR_RST, RUNS_ALARM_RST,
                                     RUNS_NORMAL_RST, RUNS_UNAV_RST, WARMUP_RST};
  level_e            stable_lvl = LVL_UNAVAIL;
  level_e            cand_lvl   = LVL_UNAVAIL;
  logic [RUN_W-1:0]  run_len    = '0;
  logic [WARM_W-1:0] warm_cnt   = '0;
  logic              warm_done  = 1'b0;

  result_t level_q[$];
  int mismatches  = 0;
  int sent_cnt    = 0;
  int taken_cnt   = 0;
  int change_cnt  = 0;
  int phase_cnt   = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic track_level(input logic ok, input logic [SMP_W-1:0] smp);
    level_e           raw;
    logic [RUN_W-1:0] need;
    result_t          r;
    r.taken   = 1'b0;
    r.changed = 1'b0;
    if (!warm_done && warm_cnt < shadow_cfg.warmup_ticks) begin
      warm_cnt = warm_cnt + 1'b1;
    end else begin
      warm_done = 1'b1;
      r.taken   = 1'b1;
      taken_cnt++;
      if (!ok) begin
        raw = LVL_UNAVAIL;
      end else if (smp > shadow_cfg.alarm_thr) begin
        raw = LVL_ALARM;
      end else if (stable_lvl == LVL_ALARM && smp > shadow_cfg.recover_thr) begin
        raw = LVL_ALARM;
      end else begin
        raw = LVL_NORMAL;
      end
      if (raw == cand_lvl) begin
        if (run_len != RUN_MAX) run_len = run_len + 1'b1;
      end else begin
        cand_lvl = raw;
        run_len  = RUN_W'(1);
      end
      case (cand_lvl)
        LVL_ALARM:  need = shadow_cfg.runs_alarm;
        LVL_NORMAL: need = shadow_cfg.runs_normal;
        default:    need = shadow_cfg.runs_unav;
      endcase
      if (need == '0) need = RUN_W'(1);
      if (cand_lvl != stable_lvl && run_len >= need) begin
        stable_lvl = cand_lvl;
        run_len    = '0;
        r.changed  = 1'b1;
        change_cnt++;
      end
    end
    r.level = stable_lvl;
    level_q.push_back(r);
  endtask

  task automatic send_sample(input logic ok, input logic [SMP_W-1:0] smp);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 20);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W - SMP_W - 1){1'b0}}, smp, ok};
    do @(posedge clk_i); while (!s_tready);
    track_level(ok, smp);
    sent_cnt++;
    burst_left--;
  endtask

  // hold off input until every queued level item has come back
  task automatic drain_results();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (level_q.size() != 0);
  endtask

  // writes all six registers, with junk above each field but the full-width warmup, then both spare indexes
  task automatic load_regs(input cfg_t c);
    logic [CFG_AW-1:0] idx;
    logic [CFG_DW-1:0] data;
    logic [CFG_DW-1:0] junk;
    for (int i = 0; i < 8; i++) begin
      junk = CFG_DW'($urandom_range(0, 16'hFFFF));
      case (i)
        0: begin idx = REG_ALARM_THR;   data = (junk << THR_W) | c.alarm_thr;   end
        1: begin idx = REG_RECOVER_THR; data = (junk << THR_W) | c.recover_thr; end
        2: begin idx = REG_RUNS_ALARM;  data = (junk << RUN_W) | c.runs_alarm;  end
        3: begin idx = REG_RUNS_NORMAL; data = (junk << RUN_W) | c.runs_normal; end
        4: begin idx = REG_RUNS_UNAV;   data = (junk << RUN_W) | c.runs_unav;   end
        5: begin idx = REG_WARMUP;      data = c.warmup_ticks;                  end
        6: begin idx = REG_SPARE_6;     data = junk;                            end
        default: begin idx = REG_SPARE_7; data = junk;                          end
      endcase
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= data;
      @(posedge clk_i);
      case (idx)
        REG_ALARM_THR:   shadow_cfg.alarm_thr    = data[THR_W-1:0];
        REG_RECOVER_THR: shadow_cfg.recover_thr  = data[THR_W-1:0];
        REG_RUNS_ALARM:  shadow_cfg.runs_alarm   = data[RUN_W-1:0];
        REG_RUNS_NORMAL: shadow_cfg.runs_normal  = data[RUN_W-1:0];
        REG_RUNS_UNAV:   shadow_cfg.runs_unav    = data[RUN_W-1:0];
        REG_WARMUP:      shadow_cfg.warmup_ticks = data[WARM_W-1:0];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_warmup();
    cfg_t c;
    c = shadow_cfg;
    c.warmup_ticks = 4;
    c.runs_alarm   = 1;
    c.runs_normal  = 1;
    c.runs_unav    = 1;
    load_regs(c);
    send_sample(1'b1, '1);
    send_sample(1'b0, '0);
    drain_results();
    // count is 2 of 4; dropping the target to zero ends warmup on the next sample
    c.warmup_ticks = 0;
    load_regs(c);
    send_sample(1'b1, '1);
    send_sample(1'b0, '0);
    send_sample(1'b1, '0);
  endtask

  task automatic test_hysteresis();
    cfg_t c;
    drain_results();
    c = '{12'd2000, 12'd1000, 8'd0, 8'd1, 8'd0, 16'hFFFF};
    load_regs(c);
    send_sample(1'b1, 12'd0);
    send_sample(1'b1, 12'd2001);
    send_sample(1'b1, 12'd2000);
    send_sample(1'b1, 12'd1001);
    send_sample(1'b1, 12'd1000);
    send_sample(1'b1, 12'd2000);
    send_sample(1'b1, 12'd2001);
    send_sample(1'b0, 12'd4095);
    send_sample(1'b1, 12'd4095);
    send_sample(1'b0, 12'd0);
    send_sample(1'b1, 12'd1500);
  endtask

  task automatic test_threshold_extremes();
    cfg_t c;
    drain_results();
    c = '{12'd0, 12'd4095, 8'd1, 8'd1, 8'd1, 16'd0};
    load_regs(c);
    send_sample(1'b1, 12'd1);
    send_sample(1'b1, 12'd0);
    send_sample(1'b1, 12'd4095);
    drain_results();
    c.alarm_thr   = 12'd4095;
    c.recover_thr = 12'd0;
    load_regs(c);
    send_sample(1'b1, 12'd4095);
    send_sample(1'b1, 12'd0);
    send_sample(1'b1, 12'd4095);
  endtask

  function automatic logic [RUN_W-1:0] pick_runs();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return RUN_MAX;
      2:       return 1;
      default: return RUN_W'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic cfg_t pick_cfg();
    cfg_t c;
    case ($urandom_range(0, 5))
      0:       c.alarm_thr = 0;
      1:       c.alarm_thr = 4095;
      default: c.alarm_thr = THR_W'($urandom_range(200, 3800));
    endcase
    case ($urandom_range(0, 5))
      0:       c.recover_thr = 0;
      1:       c.recover_thr = 4095;
      2:       c.recover_thr = c.alarm_thr;
      default: c.recover_thr = THR_W'($urandom_range(0, c.alarm_thr));
    endcase
    c.runs_alarm   = pick_runs();
    c.runs_normal  = pick_runs();
    c.runs_unav    = pick_runs();
    c.warmup_ticks = WARM_W'($urandom_range(0, 16'hFFFF));
    return c;
  endfunction

  // one stretch of samples of the same class, with the odd glitch mixed in
  task automatic play_segment(input cfg_t c, input int len);
    int               kind;
    logic             ok;
    logic [SMP_W-1:0] smp;
    logic [SMP_W-1:0] low_top;
    low_top = (c.recover_thr < c.alarm_thr) ? c.recover_thr : c.alarm_thr;
    kind    = $urandom_range(0, 4);
    for (int n = 0; n < len; n++) begin
      ok  = 1'b1;
      smp = SMP_W'($urandom_range(0, 4095));
      case (($urandom_range(0, 15) == 0) ? 4 : kind)
        0: smp = ($urandom_range(0, 3) == 0) ? low_top
                                             : SMP_W'($urandom_range(0, low_top));
        1: if (c.alarm_thr != 4095) begin
          smp = ($urandom_range(0, 3) == 0) ? c.alarm_thr + 1'b1
                                            : SMP_W'($urandom_range(c.alarm_thr + 1, 4095));
        end
        2: if (c.recover_thr < c.alarm_thr) begin
          smp = SMP_W'($urandom_range(c.recover_thr + 1, c.alarm_thr));
        end
        3: ok = 1'b0;
        default: ok = ($urandom_range(0, 7) != 0);
      endcase
      send_sample(ok, smp);
    end
  endtask

  task automatic test_random_streams(input int target);
    cfg_t c;
    int   stop_at;
    int   phase_end;
    int   len;
    stop_at = sent_cnt + target;
    while (sent_cnt < stop_at) begin
      drain_results();
      c = pick_cfg();
      load_regs(c);
      phase_cnt++;
      phase_end = sent_cnt + $urandom_range(180, 280);
      while (sent_cnt < phase_end && sent_cnt < stop_at) begin
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(256, 300)
                                           : $urandom_range(1, 24);
        if (len > stop_at - sent_cnt) len = stop_at - sent_cnt;
        play_segment(c, len);
      end
    end
  endtask

  // output stall pattern: free-running, random, sparse and hard-stall stretches
  initial begin : rx_stall
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = (mode == 3) ? $urandom_range(1, 30) : $urandom_range(16, 200);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 1) == 1);
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : chk
    result_t got;
    result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got.level   = level_e'(m_tdata[1:0]);
      got.changed = m_tdata[2];
      got.taken   = m_tdata[3];
      if (level_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: tdata=%h", m_tdata);
      end else begin
        want = level_q.pop_front();
        if (got.level !== want.level || got.changed !== want.changed ||
            got.taken !== want.taken) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: level exp %0d got %0d, changed exp %0b got %0b, taken exp %0b got %0b",
                     want.level, got.level, want.changed, got.changed, want.taken, got.taken);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d items outstanding",
               WD_LIMIT, level_q.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_warmup();
    test_hysteresis();
    test_threshold_extremes();
    test_random_streams(1880);
    drain_results();
    repeat (8) @(posedge clk_i);
    $display("sent %0d samples (%0d past warmup) over %0d random register settings",
             sent_cnt, taken_cnt, phase_cnt);
    $display("saw %0d level changes, %0d mismatches", change_cnt, mismatches);
    if (mismatches == 0 && level_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/sad_pkg.sv
hw/rtl/sad_cfg_regs.sv
hw/rtl/sad_in_stage.sv
hw/rtl/sad_core.sv
hw/rtl/sad_out_reg.sv
hw/rtl/sensor_alarm_debouncer.sv
hw/rtl/sad_checker.sv
tb/sensor_alarm_debouncer_tb.sv
